// ===== sv/sst_pkg.sv =====
// Shared types and constants for the sorted score table.
`timescale 1ns / 1ps
package sst_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned RankW      = 6;
  localparam int unsigned FieldW     = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_ACK,
    ST_DRN_RD,
    ST_DRN_OUT
  } state_e;

  typedef struct packed {
    logic signed [FieldW-1:0] score;
    logic        [FieldW-1:0] record;
  } entry_t;

  typedef struct packed {
    kind_e                    kind;
    logic        [RankW-1:0]  rank;
    logic        [FieldW-1:0] out_record;
    logic signed [FieldW-1:0] out_score;
    logic                     dropped;
    logic                     last;
  } res_t;

endpackage

// ===== sv/sst_if.sv =====
// Request and result channel interfaces for the sorted score table.
`timescale 1ns / 1ps
interface sst_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic        [sst_pkg::FieldW-1:0] record_id;
  logic signed [sst_pkg::FieldW-1:0] score;

  modport source (output valid, action, record_id, score, input ready);
  modport sink   (input valid, action, record_id, score, output ready);
endinterface

interface sst_out_if;
  logic                             valid;
  logic                             ready;
  sst_pkg::kind_e                   kind;
  logic        [sst_pkg::RankW-1:0]  rank;
  logic        [sst_pkg::FieldW-1:0] out_record;
  logic signed [sst_pkg::FieldW-1:0] out_score;
  logic                             dropped;
  logic                             last;

  modport source (output valid, kind, rank, out_record, out_score, dropped, last,
                  input ready);
  modport sink   (input valid, kind, rank, out_record, out_score, dropped, last,
                  output ready);
endinterface

// ===== sv/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sorted_score_table_unit.sv =====
// Insert: on an empty table the entry is written at once; else the table is walked up from its last entry.
// Each step is one RAM read, one signed compare and, bar a drop, one RAM write of the shifted or new entry.
// Drain: each ranked entry takes a RAM read, then the result register; an empty drain gives one EMPTY result.
// A finished result waits in an output register while the next request is taken.
// Reset (asynchronous, active low) empties the table; RAM contents are not cleared.
`timescale 1ns / 1ps
module sorted_score_table_unit #(
  parameter int unsigned TABLE_DEPTH = sst_pkg::TableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sst_in_if.sink        in_i,
  sst_out_if.source     out_o
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = AW + 1;

  state_e          state_q, state_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  entry_t          new_q, new_d;
  logic            full_q, full_d;
  res_t            pend_q, pend_d;
  res_t            res_q, res_d;
  logic            out_vld_q, out_vld_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  logic            out_free;
  logic            ge;
  logic            at_end;
  logic            drn_last;
  logic [XW-1:0]   idx_inc;
  entry_t          in_entry;
  res_t            ack_none;

  sst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign ge       = $signed(ram_rdata.score) >= $signed(new_q.score);
  assign at_end   = idx_q == AW'(TABLE_DEPTH - 1);
  assign idx_inc  = XW'(idx_q) + XW'(1);
  assign drn_last = idx_inc == XW'(cnt_q);

  always_comb begin
    in_entry.score  = in_i.score;
    in_entry.record = in_i.record_id;
    ack_none.kind       = KIND_ACK;
    ack_none.rank       = '0;
    ack_none.out_record = '0;
    ack_none.out_score  = '0;
    ack_none.dropped    = 1'b0;
    ack_none.last       = 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    new_d     = new_q;
    full_d    = full_q;
    pend_d    = pend_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !out_o.ready;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_q;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    in_i.ready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.action == ACT_DRAIN) begin
            if (cnt_q == '0) begin
              pend_d      = ack_none;
              pend_d.kind = KIND_EMPTY;
              state_d     = ST_ACK;
            end else begin
              idx_d   = '0;
              state_d = ST_DRN_RD;
            end
          end else begin
            new_d  = in_entry;
            full_d = cnt_q == CW'(TABLE_DEPTH);
            pend_d = ack_none;
            if (cnt_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_entry;
              cnt_d     = cnt_q + CW'(1);
              state_d   = ST_ACK;
            end else begin
              idx_d     = AW'(cnt_q - CW'(1));
              ram_re    = 1'b1;
              ram_raddr = AW'(cnt_q - CW'(1));
              state_d   = ST_INS_CMP;
            end
          end
        end
      end
      ST_INS_CMP: begin
        ram_waddr = AW'(idx_inc);
        if (ge) begin
          if (at_end) begin
            pend_d.out_record = new_q.record;
            pend_d.out_score  = new_q.score;
            pend_d.dropped    = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = new_q;
            if (!full_q) begin
              cnt_d = cnt_q + CW'(1);
            end
          end
          state_d = ST_ACK;
        end else begin
          if (at_end) begin
            pend_d.out_record = ram_rdata.record;
            pend_d.out_score  = ram_rdata.score;
            pend_d.dropped    = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
          end
          if (idx_q == '0) begin
            state_d = ST_INS_PUT;
          end else begin
            idx_d     = idx_q - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
          end
        end
      end
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_q;
        if (!full_q) begin
          cnt_d = cnt_q + CW'(1);
        end
        state_d = ST_ACK;
      end
      ST_ACK: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          res_d     = pend_q;
          state_d   = ST_IDLE;
        end
      end
      ST_DRN_RD: begin
        ram_re  = 1'b1;
        state_d = ST_DRN_OUT;
      end
      ST_DRN_OUT: begin
        if (out_free) begin
          out_vld_d        = 1'b1;
          res_d.kind       = KIND_ENTRY;
          res_d.rank       = RankW'(idx_inc);
          res_d.out_record = ram_rdata.record;
          res_d.out_score  = ram_rdata.score;
          res_d.dropped    = 1'b0;
          res_d.last       = drn_last;
          if (drn_last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = AW'(idx_inc);
            state_d = ST_DRN_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      full_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      full_q    <= full_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.rank       = res_q.rank;
  assign out_o.out_record = res_q.out_record;
  assign out_o.out_score  = res_q.out_score;
  assign out_o.dropped    = res_q.dropped;
  assign out_o.last       = res_q.last;

endmodule

// ===== sv/sst_chk.sv =====
// Port-level assertion checker for the sorted score table, bound to the top level.
`timescale 1ns / 1ps
module sst_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [1:0]                        out_kind_i,
  input  logic [sst_pkg::RankW-1:0]         out_rank_i,
  input  logic [sst_pkg::FieldW-1:0]        out_record_i,
  input  logic [sst_pkg::FieldW-1:0]        out_score_i,
  input  logic                              out_dropped_i,
  input  logic                              out_last_i
);
  import sst_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in progress");

  a_no_accept_mid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready raised before drain finished");

  a_rank_only_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_ENTRY) |-> out_rank_i == '0)
    else $error("nonzero rank on non-entry result");

  a_drop_only_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_dropped_i |-> out_kind_i == KIND_ACK)
    else $error("dropped flag on non-acknowledge result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_rank_i) && $stable(out_record_i) && $stable(out_score_i)
      && $stable(out_dropped_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind sorted_score_table_unit sst_chk u_sst_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_kind_i    (out_o.kind),
  .out_rank_i    (out_o.rank),
  .out_record_i  (out_o.out_record),
  .out_score_i   (out_o.out_score),
  .out_dropped_i (out_o.dropped),
  .out_last_i    (out_o.last)
);
